### src/shfs_pkg.sv
// Shared types and constants for the spectrum height field scroller.
// Holds the beat structs, the sequencer states, the fixed-point limits and
// the gradient colour function. Depends on nothing.
package shfs_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int COLOR_W   = 24;
  localparam int HEIGHT_W  = 18;
  localparam int SPEED_W   = 18;
  localparam int MAX_EMIT  = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLOR_ZERO  = 3'd0,
    CFG_COLOR_ONE   = 3'd1,
    CFG_COLOR_TWO   = 3'd2,
    CFG_COLOR_THREE = 3'd3,
    CFG_COLOR_FOUR  = 3'd4
  } cfg_index_t;

  localparam logic [COLOR_W-1:0] COLOR_ZERO_RST  = 24'h1C6B18;
  localparam logic [COLOR_W-1:0] COLOR_ONE_RST   = 24'hFF0A23;
  localparam logic [COLOR_W-1:0] COLOR_TWO_RST   = 24'h2A1D74;
  localparam logic [COLOR_W-1:0] COLOR_THREE_RST = 24'h9036D9;
  localparam logic [COLOR_W-1:0] COLOR_FOUR_RST  = 24'h6B88FF;

  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 18'h3FFFF;
  localparam logic [SPEED_W-1:0]  SPEED_MIN  = 18'h20000;

  // Exact reciprocals for numerators below 2^22: q = (n * RECIP) >> SHIFT
  localparam logic [22:0] RECIP_425 = 23'd5052903;
  localparam int          SHIFT_425 = 31;
  localparam logic [22:0] RECIP_45  = 23'd5965233;
  localparam int          SHIFT_45  = 28;

  localparam logic [21:0] ROUND_425 = 22'd212;
  localparam logic [21:0] ROUND_45  = 22'd22;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic [5:0] column;
    logic [7:0] sample_a;
    logic [7:0] sample_b;
    logic [7:0] sample_c;
  } in_item_t;

  typedef struct packed {
    logic [5:0]          row;
    logic [5:0]          point_column;
    logic [HEIGHT_W-1:0] height;
    logic [COLOR_W-1:0]  dot_color;
    logic                last;
  } out_item_t;

  // Entry idx of the 64-step gradient: four segments of 16 steps each,
  // channel value a + floor(x * (b - a) / 16).
  function automatic logic [COLOR_W-1:0] grad_color(
    input logic [COLOR_W-1:0] c0,
    input logic [COLOR_W-1:0] c1,
    input logic [COLOR_W-1:0] c2,
    input logic [COLOR_W-1:0] c3,
    input logic [COLOR_W-1:0] c4,
    input logic [5:0]         idx
  );
    logic [COLOR_W-1:0] ca;
    logic [COLOR_W-1:0] cb;
    logic [COLOR_W-1:0] res;
    logic [7:0]         a;
    logic [7:0]         b;
    logic signed [8:0]  d;
    logic signed [13:0] p;
    logic signed [13:0] q;
    logic [9:0]         v;
    case (idx[5:4])
      2'd0: begin
        ca = c0;
        cb = c1;
      end
      2'd1: begin
        ca = c1;
        cb = c2;
      end
      2'd2: begin
        ca = c2;
        cb = c3;
      end
      default: begin
        ca = c3;
        cb = c4;
      end
    endcase
    res = '0;
    for (int ch = 0; ch < 3; ch++) begin
      a = ca[8*ch +: 8];
      b = cb[8*ch +: 8];
      d = $signed({1'b0, b}) - $signed({1'b0, a});
      p = $signed({1'b0, idx[3:0]}) * d;
      q = p >>> 4;
      v = {2'b00, a} + q[9:0];
      res[8*ch +: 8] = v[7:0];
    end
    return res;
  endfunction

endpackage

### src/spectrum_height_field_scroller.sv
// Spectrum height field scroller: top level, sequencer and row pipeline.
// Uses shfs_pkg for beat structs and constants, shfs_ram for the three
// grid stores (height, speed, colour).
//
//  channel | signals                          | direction | beat
//  --------+----------------------------------+-----------+-------------------------
//  input   | in_valid, in_ready, in_data      | in        | column + three samples
//  output  | out_valid, out_ready, out_data   | out       | one grid point per beat
//  config  | cfg_we, cfg_index, cfg_data      | in        | one colour register write
//
// A column item is accepted only while the sequencer is idle, and ready returns once
// its rows have left the row pipeline: the sequencer issues one row per cycle, while
// the output is not held, through a single read port of the stores, and one shared
// reciprocal multiplier serves every row. An item for a column outside the grid is taken
// and dropped. A held output beat stalls the whole row pipeline, stores included.
// Reset is synchronous; the stores need no clearing pass, since a column not
// yet fed since reset reads as zero through its own valid bit.
module spectrum_height_field_scroller #(
  parameter int GRID_SIZE = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  shfs_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output shfs_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [shfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [shfs_pkg::COLOR_W-1:0]    cfg_data
);

  import shfs_pkg::*;

  localparam int CW        = $clog2(GRID_SIZE);
  localparam int AW        = 2 * CW;
  localparam int MEM_DEPTH = 1 << AW;
  localparam int EMIT_ROWS = (GRID_SIZE < MAX_EMIT) ? GRID_SIZE : MAX_EMIT;

  localparam logic [CW:0]   GRID_CNT = (CW+1)'(GRID_SIZE);
  localparam logic [CW:0]   EMIT_CNT = (CW+1)'(EMIT_ROWS);
  localparam logic [CW-1:0] LAST_ROW = CW'(EMIT_ROWS - 1);

  // configuration
  logic [COLOR_W-1:0] color_zero;
  logic [COLOR_W-1:0] color_one;
  logic [COLOR_W-1:0] color_two;
  logic [COLOR_W-1:0] color_three;
  logic [COLOR_W-1:0] color_four;

  // sequencer
  state_t       state;
  state_t       state_next;
  logic [CW:0]  issue_cnt;
  logic         issue_done;
  logic         issue;
  logic         adv;
  logic         in_fire;
  logic         in_grid;
  logic         start;
  logic [CW-1:0] in_col_idx;

  // item registers
  logic [5:0]    col_r;
  logic [CW-1:0] col_idx;
  logic [7:0]    m_r;
  logic [7:0]    m_next;
  logic          fresh_r;
  logic [GRID_SIZE-1:0] col_valid;

  // store ports
  logic [CW-1:0]       rd_row;
  logic [AW-1:0]       raddr;
  logic [AW-1:0]       waddr;
  logic                ram_we;
  logic [HEIGHT_W-1:0] rd_h;
  logic [SPEED_W-1:0]  rd_v;
  logic [COLOR_W-1:0]  rd_c;

  // read stage
  logic          r_valid;
  logic          r_row0;
  logic [CW-1:0] r_row;

  // stage A
  logic [HEIGHT_W-1:0] old_h;
  logic [SPEED_W-1:0]  old_v;
  logic [COLOR_W-1:0]  old_c;
  logic [HEIGHT_W-1:0] front_h;
  logic [18:0]         diff;
  logic                front_neg;
  logic [17:0]         mag;
  logic [21:0]         front_n;
  logic [23:0]         sum;
  logic [HEIGHT_W-1:0] moved_h;
  logic [21:0]         moved_n;
  logic [COLOR_W-1:0]  front_color;

  logic                a_valid;
  logic                a_row0;
  logic                a_neg;
  logic [CW-1:0]       a_row;
  logic [HEIGHT_W-1:0] a_h;
  logic [21:0]         a_n;
  logic [SPEED_W-1:0]  a_oldv;
  logic [COLOR_W-1:0]  a_color;

  // stage B: shared reciprocal multiplier
  logic [22:0] mul;
  logic [44:0] prod;
  logic [15:0] quot;

  logic                b_valid;
  logic                b_row0;
  logic                b_neg;
  logic [CW-1:0]       b_row;
  logic [HEIGHT_W-1:0] b_h;
  logic [15:0]         b_q;
  logic [SPEED_W-1:0]  b_oldv;
  logic [COLOR_W-1:0]  b_color;

  // write / emit stage
  logic [SPEED_W-1:0] sq;
  logic [SPEED_W-1:0] front_v;
  logic [18:0]        dec;
  logic [SPEED_W-1:0] moved_v;
  logic [SPEED_W-1:0] new_v;
  logic               out_load;
  out_item_t          out_next;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      color_zero  <= COLOR_ZERO_RST;
      color_one   <= COLOR_ONE_RST;
      color_two   <= COLOR_TWO_RST;
      color_three <= COLOR_THREE_RST;
      color_four  <= COLOR_FOUR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLOR_ZERO:  color_zero  <= cfg_data;
        CFG_COLOR_ONE:   color_one   <= cfg_data;
        CFG_COLOR_TWO:   color_two   <= cfg_data;
        CFG_COLOR_THREE: color_three <= cfg_data;
        CFG_COLOR_FOUR:  color_four  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign adv        = !out_valid || out_ready;
  assign issue_done = (issue_cnt == GRID_CNT);
  assign in_fire    = in_valid && in_ready;
  assign in_grid    = {26'd0, in_data.column} < 32'(GRID_SIZE);
  assign start      = in_fire && in_grid;
  assign in_col_idx = CW'(in_data.column);
  assign col_idx    = CW'(col_r);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (issue_done && !r_valid && !a_valid && (!b_valid || adv)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_RUN:  issue    = adv && !issue_done;
      default: ;
    endcase
  end

  always_comb begin
    m_next = in_data.sample_a;
    if (in_data.sample_b > m_next) begin
      m_next = in_data.sample_b;
    end
    if (in_data.sample_c > m_next) begin
      m_next = in_data.sample_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      col_valid <= '0;
    end else begin
      state <= state_next;
      if (start) begin
        col_valid[in_col_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      col_r     <= in_data.column;
      m_r       <= m_next;
      fresh_r   <= !col_valid[in_col_idx];
      issue_cnt <= '0;
    end else if (issue) begin
      issue_cnt <= issue_cnt + 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Grid stores: slot k reads row k-1 (row 0 for slot 0) and writes row k
  // ---------------------------------------------------------------------------
  assign rd_row = (issue_cnt == '0) ? '0 : issue_cnt[CW-1:0] - 1'b1;
  assign raddr  = {rd_row, col_idx};
  assign waddr  = {b_row, col_idx};
  assign ram_we = b_valid && adv;

  shfs_ram #(.WIDTH(HEIGHT_W), .DEPTH(MEM_DEPTH)) u_height_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (b_h),
    .re    (adv),
    .raddr (raddr),
    .rdata (rd_h)
  );

  shfs_ram #(.WIDTH(SPEED_W), .DEPTH(MEM_DEPTH)) u_speed_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (new_v),
    .re    (adv),
    .raddr (raddr),
    .rdata (rd_v)
  );

  shfs_ram #(.WIDTH(COLOR_W), .DEPTH(MEM_DEPTH)) u_color_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (b_color),
    .re    (adv),
    .raddr (raddr),
    .rdata (rd_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (adv) begin
      r_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_row0 <= (issue_cnt == '0);
      r_row  <= issue_cnt[CW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: advance height, or build the front row from the new sample
  // ---------------------------------------------------------------------------
  always_comb begin
    // a column untouched since reset reads as zero
    old_h = fresh_r ? '0 : rd_h;
    old_v = fresh_r ? '0 : rd_v;
    old_c = fresh_r ? '0 : rd_c;

    front_h   = {2'b00, m_r, 8'h00};
    diff      = {1'b0, front_h} - {1'b0, old_h};
    front_neg = diff[18];
    mag       = front_neg ? 18'(~diff + 19'd1) : diff[17:0];
    front_n   = {1'b0, mag, 3'b000} + ROUND_45;

    sum = {2'b00, old_h, 4'h0} + {{6{old_v[17]}}, old_v};
    if (sum[23]) begin
      moved_h = '0;
    end else if (sum[22]) begin
      moved_h = HEIGHT_MAX;
    end else begin
      moved_h = sum[21:4];
    end
    moved_n = {2'b00, moved_h, 2'b00} + ROUND_425;

    front_color = grad_color(color_zero, color_one, color_two, color_three,
                             color_four, m_r[7:2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_row0  <= r_row0;
      a_row   <= r_row;
      a_neg   <= front_neg;
      a_h     <= r_row0 ? front_h : moved_h;
      a_n     <= r_row0 ? front_n : moved_n;
      a_oldv  <= old_v;
      a_color <= r_row0 ? front_color : old_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: divide by 45 (front row) or 425 (moved rows) by reciprocal
  // ---------------------------------------------------------------------------
  assign mul  = a_row0 ? RECIP_45 : RECIP_425;
  assign prod = a_n * mul;
  assign quot = a_row0 ? prod[SHIFT_45+15:SHIFT_45] : {2'b00, prod[44:SHIFT_425]};

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_row0  <= a_row0;
      b_row   <= a_row;
      b_neg   <= a_neg;
      b_h     <= a_h;
      b_q     <= quot;
      b_oldv  <= a_oldv;
      b_color <= a_color;
    end
  end

  // ---------------------------------------------------------------------------
  // Write back and emit
  // ---------------------------------------------------------------------------
  always_comb begin
    sq      = {2'b00, b_q};
    front_v = b_neg ? (~sq + 18'd1) : sq;
    // only underflow can occur: the decrement is never negative
    dec     = {b_oldv[17], b_oldv} - {3'b000, b_q};
    moved_v = (dec[18] != dec[17]) ? SPEED_MIN : dec[17:0];
    new_v   = b_row0 ? front_v : moved_v;
  end

  assign out_load = b_valid && ({1'b0, b_row} < EMIT_CNT);

  always_comb begin
    out_next.row          = 6'(b_row);
    out_next.point_column = col_r;
    out_next.height       = b_h;
    out_next.dot_color    = b_color;
    out_next.last         = (b_row == LAST_ROW);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && out_load) begin
      out_data <= out_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_idle_empty : assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !(r_valid || a_valid || b_valid))
    else $error("row pipeline busy while idle");

  a_issue_bound : assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (issue_cnt <= GRID_CNT))
    else $error("row issue count past grid size");

  a_stall_hold : assert property (@(posedge clk) disable iff (rst)
    (!adv && b_valid) |=> (b_valid && $stable(b_row) && $stable(b_h)))
    else $error("write stage moved during output stall");

endmodule

### src/shfs_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Read data holds while the read enable is low. No package dependency.
module shfs_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### bench/height_field_checker.sv
`timescale 1ns / 1ps
// Checker for the spectrum height field scroller: watches the column, point and
// register channels, keeps its own copy of the grid and flags every point that differs.
// Depends on shfs_pkg for the beat structs and widths.
module height_field_checker #(
  parameter int GRID = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  shfs_pkg::in_item_t             in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  shfs_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [shfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [shfs_pkg::COLOR_W-1:0]   cfg_data,
  output int                             mismatches,
  output int                             points_pending
);

  import shfs_pkg::*;

  localparam int CELLS        = GRID * GRID;
  localparam int EMIT         = (GRID < MAX_EMIT) ? GRID : MAX_EMIT;
  localparam int SEG_STEPS    = 16;
  localparam int HEIGHT_LIMIT = 2 ** HEIGHT_W - 1;
  localparam int SPEED_HI     = 2 ** (SPEED_W - 1) - 1;
  localparam int SPEED_LO     = -(2 ** (SPEED_W - 1));
  localparam int PRINT_CAP    = 40;

  logic [HEIGHT_W-1:0]       height_grid [CELLS];
  logic signed [SPEED_W-1:0] speed_grid  [CELLS];
  logic [COLOR_W-1:0]        color_grid  [CELLS];
  logic [COLOR_W-1:0]        colour_regs [5];
  out_item_t                 points_due  [$];

  initial begin
    mismatches     = 0;
    points_pending = 0;
  end

  function automatic int clamp_speed(input int v);
    if (v > SPEED_HI) return SPEED_HI;
    if (v < SPEED_LO) return SPEED_LO;
    return v;
  endfunction

  // Walk from one register colour towards the next, flooring each channel step.
  function automatic logic [COLOR_W-1:0] palette_entry(input int idx);
    int                 seg;
    int                 pos;
    int                 a;
    int                 b;
    int                 v;
    logic [COLOR_W-1:0] packed_rgb;
    seg        = idx / SEG_STEPS;
    pos        = idx % SEG_STEPS;
    packed_rgb = '0;
    for (int ch = 0; ch < 3; ch++) begin
      a = int'(colour_regs[seg][8*ch +: 8]);
      b = int'(colour_regs[seg+1][8*ch +: 8]);
      v = a + ((pos * (b - a)) >>> 4);
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      packed_rgb[8*ch +: 8] = 8'(v);
    end
    return packed_rgb;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (mismatches < PRINT_CAP)
      $display("%0t checker: %s got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic scroll_column(input in_item_t beat);
    int        col;
    int        src;
    int        dst;
    int        sum;
    int        h;
    int        dec;
    int        peak;
    int        diff;
    int        mag;
    int        idx;
    out_item_t pt;
    col = int'(beat.column);
    if (col >= GRID) return;
    // Shift back to front so each source is read before it is overwritten.
    for (int r = GRID - 1; r >= 1; r--) begin
      src = (r - 1) * GRID + col;
      dst = r * GRID + col;
      sum = 16 * int'(height_grid[src]) + int'(speed_grid[src]);
      if (sum < 0) sum = 0;
      h = sum >>> 4;
      if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
      dec = (4 * h + 212) / 425;
      height_grid[dst] = HEIGHT_W'(h);
      speed_grid[dst]  = SPEED_W'(clamp_speed(int'(speed_grid[src]) - dec));
      color_grid[dst]  = color_grid[src];
    end
    peak = int'(beat.sample_a);
    if (int'(beat.sample_b) > peak) peak = int'(beat.sample_b);
    if (int'(beat.sample_c) > peak) peak = int'(beat.sample_c);
    diff = peak * 256 - int'(height_grid[col]);
    mag  = (diff < 0) ? -diff : diff;
    mag  = (mag * 8 + 22) / 45;
    idx  = peak >> 2;
    if (idx > 63) idx = 63;
    height_grid[col] = HEIGHT_W'(peak * 256);
    speed_grid[col]  = SPEED_W'(clamp_speed((diff < 0) ? -mag : mag));
    color_grid[col]  = palette_entry(idx);
    for (int n = 0; n < EMIT; n++) begin
      pt.row          = 6'(n);
      pt.point_column = 6'(col);
      pt.height       = height_grid[n * GRID + col];
      pt.dot_color    = color_grid[n * GRID + col];
      pt.last         = (n == EMIT - 1);
      points_due.push_back(pt);
    end
  endtask

  task automatic check_point(input out_item_t got);
    out_item_t want;
    if (points_due.size() == 0) begin
      flag_mismatch("point with nothing pending, row", 32'(got.row), '0);
      return;
    end
    want = points_due.pop_front();
    if (got.row !== want.row) flag_mismatch("row", 32'(got.row), 32'(want.row));
    if (got.point_column !== want.point_column)
      flag_mismatch("point_column", 32'(got.point_column), 32'(want.point_column));
    if (got.height !== want.height)
      flag_mismatch("height", 32'(got.height), 32'(want.height));
    if (got.dot_color !== want.dot_color)
      flag_mismatch("dot_color", 32'(got.dot_color), 32'(want.dot_color));
    if (got.last !== want.last) flag_mismatch("last", 32'(got.last), 32'(want.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CELLS; k++) begin
        height_grid[k] = '0;
        speed_grid[k]  = '0;
        color_grid[k]  = '0;
      end
      colour_regs[CFG_COLOR_ZERO]  = COLOR_ZERO_RST;
      colour_regs[CFG_COLOR_ONE]   = COLOR_ONE_RST;
      colour_regs[CFG_COLOR_TWO]   = COLOR_TWO_RST;
      colour_regs[CFG_COLOR_THREE] = COLOR_THREE_RST;
      colour_regs[CFG_COLOR_FOUR]  = COLOR_FOUR_RST;
      points_due.delete();
    end else begin
      // Writes beyond the last colour register are dropped.
      if (cfg_we && cfg_index <= CFG_COLOR_FOUR) colour_regs[cfg_index] = cfg_data;
      if (in_valid && in_ready) scroll_column(in_data);
      if (out_valid && out_ready) check_point(out_data);
    end
    points_pending = points_due.size();
  end

endmodule

### bench/spectrum_height_field_scroller_tb.sv
`timescale 1ns / 1ps
// Testbench top for the spectrum height field scroller: clock, reset, column beats,
// output back-pressure and colour register phases. Uses shfs_pkg and height_field_checker.
module spectrum_height_field_scroller_tb;
  import shfs_pkg::*;

  localparam int GRID            = 64;
  localparam int ITEM_CYCLES     = GRID + 4;
  localparam int NUM_COLOUR_REGS = 5;
  localparam int IDX_TOP         = 2 ** CFG_IDX_W - 1;
  localparam int PHASES          = 6;
  localparam int PHASE_ITEMS     = 77;
  localparam int HOT_COLUMNS     = 4;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COLOR_W-1:0]   cfg_data  = '0;
  int                   mismatches;
  int                   points_pending;

  int burst_left = 0;
  int stall_left = 0;
  int stall_pct  = 0;
  int mode_left  = 0;
  int envelope [GRID];
  int hot [HOT_COLUMNS];

  always #6 clk = ~clk;

  spectrum_height_field_scroller #(
    .GRID_SIZE(GRID)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  height_field_checker #(
    .GRID(GRID)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .points_pending(points_pending)
  );

  // Receiver: random stall runs, with the stall rate redrawn from 0, 12 or 50 percent at random intervals.
  always @(negedge clk) begin
    if (mode_left == 0) begin
      case ($urandom_range(2))
        0: stall_pct <= 0;
        1: stall_pct <= 12;
        default: stall_pct <= 50;
      endcase
      mode_left <= $urandom_range(100, 400);
    end else begin
      mode_left <= mode_left - 1;
    end
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(99) < stall_pct) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    #12_000_000;
    $display("tb: failure");
    $finish;
  end

  // Hold the beat until it is taken; return on the following falling edge.
  task automatic push_column(input in_item_t beat);
    in_data  <= beat;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_column(input in_item_t beat);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(3))
        0: gap = 0;
        1: gap = $urandom_range(1, 8);
        2: gap = $urandom_range(20, 90);
        default: gap = $urandom_range(ITEM_CYCLES - 6, ITEM_CYCLES + 2);
      endcase
      if ($urandom_range(7) == 0) burst_left = $urandom_range(20, 50);
      else burst_left = $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    push_column(beat);
  endtask

  task automatic send_samples(input int col, input int a, input int b, input int c);
    in_item_t beat;
    beat.column   = 6'(col);
    beat.sample_a = 8'(a);
    beat.sample_b = 8'(b);
    beat.sample_c = 8'(c);
    send_column(beat);
  endtask

  // Drain every pending point, then let the pipeline settle before touching registers.
  task automatic drain;
    in_valid  <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (points_pending != 0) @(negedge clk);
    repeat (ITEM_CYCLES) @(negedge clk);
  endtask

  task automatic write_colour_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [COLOR_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_colours(input logic [COLOR_W-1:0] c0, input logic [COLOR_W-1:0] c1,
                              input logic [COLOR_W-1:0] c2, input logic [COLOR_W-1:0] c3,
                              input logic [COLOR_W-1:0] c4);
    write_colour_reg(CFG_COLOR_ZERO, c0);
    write_colour_reg(CFG_COLOR_ONE, c1);
    write_colour_reg(CFG_COLOR_TWO, c2);
    write_colour_reg(CFG_COLOR_THREE, c3);
    write_colour_reg(CFG_COLOR_FOUR, c4);
    // Out-of-range index: must leave the palette alone.
    write_colour_reg(CFG_IDX_W'($urandom_range(IDX_TOP, NUM_COLOUR_REGS)), COLOR_W'($urandom));
  endtask

  task automatic random_column;
    in_item_t beat;
    int       col;
    int       lvl;
    int       which;
    if ($urandom_range(4) != 0) col = hot[$urandom_range(HOT_COLUMNS - 1)];
    else col = $urandom_range(GRID - 1);
    beat.column = 6'(col);
    if ($urandom_range(3) != 0) begin
      // Smooth envelope per column, peak carried by one of the three samples.
      lvl = envelope[col] + int'($urandom_range(80)) - 40;
      if (lvl < 0) lvl = 0;
      if (lvl > 255) lvl = 255;
      envelope[col] = lvl;
      which         = $urandom_range(2);
      beat.sample_a = 8'((which == 0) ? lvl : $urandom_range(lvl));
      beat.sample_b = 8'((which == 1) ? lvl : $urandom_range(lvl));
      beat.sample_c = 8'((which == 2) ? lvl : $urandom_range(lvl));
    end else if ($urandom_range(1) == 0) begin
      beat.sample_a = 8'($urandom);
      beat.sample_b = 8'($urandom);
      beat.sample_c = 8'($urandom);
    end else begin
      beat.sample_a = 8'($urandom_range(1) ? 255 : 0);
      beat.sample_b = 8'($urandom_range(1) ? 255 : 0);
      beat.sample_c = 8'($urandom_range(1) ? 255 : 0);
    end
    send_column(beat);
  endtask

  initial begin
    for (int k = 0; k < GRID; k++) envelope[k] = 0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed beats on the reset palette.
    send_samples(0, 0, 0, 0);
    send_samples(63, 255, 255, 255);
    send_samples(0, 255, 0, 0);
    send_samples(0, 0, 255, 0);
    send_samples(0, 0, 0, 255);
    send_samples(0, 0, 0, 0);
    send_samples(63, 0, 0, 0);
    send_samples(63, 0, 0, 0);
    send_samples(63, 255, 0, 0);
    send_samples(63, 0, 0, 0);
    send_samples(21, 63, 0, 0);
    send_samples(21, 0, 64, 0);
    send_samples(21, 0, 0, 127);
    send_samples(21, 128, 0, 0);
    send_samples(21, 0, 191, 0);
    send_samples(21, 0, 0, 192);
    send_samples(21, 252, 3, 7);
    send_samples(0, 170, 85, 170);
    send_samples(63, 85, 170, 85);
    send_samples(42, 1, 2, 1);
    send_samples(63, 0, 0, 1);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: load_colours('0, '0, '0, '0, '0);
        1: load_colours('1, '1, '1, '1, '1);
        2: load_colours('0, '1, '0, '1, '0);
        3: load_colours('1, '0, '1, '0, '1);
        default: load_colours(COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom),
                              COLOR_W'($urandom), COLOR_W'($urandom));
      endcase
      for (int h = 0; h < HOT_COLUMNS; h++) hot[h] = $urandom_range(GRID - 1);
      // Keep both edge columns busy in one phase.
      if (p == 2) begin
        hot[0] = 0;
        hot[1] = GRID - 1;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) random_column();
    end

    drain();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
